FILE: hdl/link_quality_parent_selector_top_macros.svh
// Assertion macros shared by the link quality parent selector RTL.
`ifndef LINK_QUALITY_PARENT_SELECTOR_TOP_MACROS_SVH
`define LINK_QUALITY_PARENT_SELECTOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define LQPS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LQPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LQPS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LQPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/lqps_pkg.sv
// Types, constants and codes of the link quality parent selector.
package lqps_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int DIVIDEND_W = 17;
    localparam int DIVISOR_W  = 11;

    localparam logic [1:0] REQ_BEACON  = 2'd0;
    localparam logic [1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    localparam logic [2:0] CFG_SINK_MODE    = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd1;
    localparam logic [2:0] CFG_DWELL        = 3'd2;
    localparam logic [2:0] CFG_BETTER_PCT   = 3'd3;
    localparam logic [2:0] CFG_MARGIN_PCT   = 3'd4;
    localparam logic [2:0] CFG_MIN_SAMPLES  = 3'd5;
    localparam logic [2:0] CFG_WINS         = 3'd6;

    localparam logic [15:0] NO_METRIC  = 16'hFFFF;
    localparam logic [15:0] GAP_LIMIT  = 16'd1000;
    localparam logic [10:0] SAT_LIMIT  = 11'd1000;
    localparam logic [7:0]  STREAK_MAX = 8'd255;
    localparam logic [6:0]  PCT_SCALE  = 7'd100;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] sender_addr;
        logic [15:0] beacon_seq;
        logic [15:0] beacon_metric;
        logic [31:0] now_time;
    } t_in;

    typedef struct packed {
        logic [15:0] parent_addr;
        logic [15:0] node_metric;
        logic [15:0] seq_to_forward;
        logic [6:0]  link_percent;
        logic [9:0]  link_samples;
        logic        parent_changed;
        logic        forward_beacon;
        logic        entry_missing;
    } t_out;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] prev_seq;
        logic [10:0] received;
        logic [10:0] expected;
        logic [31:0] last_heard;
        logic [7:0]  streak;
    } t_nbr;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
    } t_div_stat;

endpackage

FILE: hdl/lqps_table.sv
// Neighbor table memory with one read port, one write port and valid flags.
module lqps_table
    import lqps_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [IDX_W-1:0]         i_rd_idx,
    output t_nbr                     o_rd_data,
    input  logic                     i_wr_en,
    input  logic [IDX_W-1:0]         i_wr_idx,
    input  t_nbr                     i_wr_data,
    output logic [TABLE_ENTRIES-1:0] o_valid
);

    t_nbr r_mem [TABLE_ENTRIES];
    t_nbr r_rd_data;
    logic [TABLE_ENTRIES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    // An entry becomes valid on its first write and stays valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_valid   = r_valid;

endmodule

FILE: hdl/lqps_div.sv
// Restoring divider that produces one quotient bit per cycle.
`include "link_quality_parent_selector_top_macros.svh"
module lqps_div
    import lqps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output t_div_stat             o_stat
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W:0]    r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dv;
    logic [DIVISOR_W:0]    w_sh;
    logic                  w_ge;

    assign w_sh = {r_rem[DIVISOR_W-1:0], r_quo[DIVIDEND_W-1]};
    assign w_ge = w_sh >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_dv}) : w_sh;
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quo;

    `LQPS_ASSERT_IMPLIES(a_no_restart, i_clk, i_rst_n, i_start, !r_busy)

endmodule

FILE: hdl/link_quality_parent_selector_top.sv
// Top level of the link quality parent selector: sequencer, registers, result stage.
//
//  Channel | Direction | Handshake                      | Payload
//  --------+-----------+--------------------------------+-------------
//  in      | input     | i_in_valid / o_in_ready        | i_in_data
//  out     | output    | o_out_valid / i_out_ready      | o_out_data
//  cfg     | input     | i_cfg_we (no wait)             | i_cfg_idx, i_cfg_wdata
//
// A beacon or query transaction goes from acceptance to a valid result through
// a scan of the table through the memory read port, an update state, two
// divisions on the shared divider (start, 17 quotient bits, done), a decision
// state and an output load state. A timeout or unused request goes from
// acceptance straight to the decision and output load states.
// Reset is synchronous and active low; it clears the valid flags of the table
// at once, so no clearing pass is needed. A finished result waits in the
// output register, and the next transaction is accepted while it waits; a
// further result stalls in the sequencer until the output register empties.
`include "link_quality_parent_selector_top_macros.svh"
module link_quality_parent_selector_top
    import lqps_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_UPD, ST_C_GO, ST_C_WAIT,
        ST_P_GO, ST_P_WAIT, ST_DECIDE, ST_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic        r_sink;
    logic [31:0] r_timeout;
    logic [31:0] r_dwell_ticks;
    logic [6:0]  r_better_pct;
    logic [6:0]  r_margin_pct;
    logic [9:0]  r_min_samples;
    logic [7:0]  r_wins;

    // Node state.
    logic [15:0] r_parent;
    logic [15:0] r_hop;
    logic [15:0] r_own_seq;
    logic [31:0] r_dwell_until;
    logic [31:0] r_heard_at;

    // Per-transaction working registers.
    t_in              r_req;
    logic [CNT_W-1:0] r_idx;
    logic             r_chk_v;
    logic [IDX_W-1:0] r_chk_idx;
    logic             r_s_hit;
    logic [IDX_W-1:0] r_s_idx;
    logic             r_p_hit;
    logic [IDX_W-1:0] r_p_idx;
    logic [10:0]      r_p_rec;
    logic [10:0]      r_p_exp;
    logic             r_f_hit;
    logic [IDX_W-1:0] r_f_idx;
    t_nbr             r_ent;
    logic             r_k_ok;
    logic [IDX_W-1:0] r_k_idx;
    logic [DIVIDEND_W-1:0] r_pc;
    logic [DIVIDEND_W-1:0] r_pp;

    // The decided result is held here until the output register is free.
    t_out r_res;
    logic r_out_valid;
    t_out r_out;

    // Table and divider wiring.
    t_nbr                     w_rd_data;
    logic [TABLE_ENTRIES-1:0] w_valid;
    logic                     w_wr_en;
    logic                     w_div_start;
    logic [DIVIDEND_W-1:0]    w_div_dvd;
    logic [DIVISOR_W-1:0]     w_div_dvs;
    t_div_stat                w_div;
    logic                     w_scan_end;
    logic                     w_chk_valid;
    t_nbr                     w_base;
    t_nbr                     w_cnt_ent;
    logic                     w_load;
    logic                     w_div_wait;
    logic                     w_out_chg;

    // Decision results.
    t_nbr        n_ent;
    t_out        n_out;
    logic [15:0] n_parent;
    logic [15:0] n_hop;
    logic [15:0] n_own_seq;
    logic [31:0] n_dwell_until;
    logic [31:0] n_heard_at;
    logic        n_wr;

    // Sequence-gap bookkeeping of one beacon on one table entry.
    function automatic t_nbr f_count(input t_nbr e, input logic [15:0] seq,
                                     input logic [31:0] now);
        t_nbr        r;
        logic [15:0] gap;
        logic [10:0] ex;
        logic [10:0] rc;
        r = e;
        r.last_heard = now;
        gap = seq - e.prev_seq;
        ex = e.expected + gap[10:0];
        rc = e.received + 11'd1;
        if (e.expected == 11'd0 && e.received == 11'd0) begin
            r.prev_seq = seq;
            r.received = 11'd1;
            r.expected = 11'd1;
        end else if (gap != 16'd0) begin
            r.prev_seq = seq;
            if (gap > GAP_LIMIT) begin
                r.received = 11'd1;
                r.expected = 11'd1;
            end else begin
                if (ex > SAT_LIMIT || rc > SAT_LIMIT) begin
                    ex = 11'(({1'b0, ex} + 12'd1) >> 1);
                    rc = 11'(({1'b0, rc} + 12'd1) >> 1);
                    if (ex == 11'd0) begin
                        ex = 11'd1;
                    end
                end
                r.expected = ex;
                r.received = rc;
            end
        end
        return r;
    endfunction

    lqps_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (r_idx[IDX_W-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (r_k_idx),
        .i_wr_data (n_ent),
        .o_valid   (w_valid)
    );

    lqps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_stat     (w_div)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_scan_end  = !r_chk_v && (r_idx == CNT_W'(TABLE_ENTRIES));
    assign w_chk_valid = w_valid[r_chk_idx];
    assign w_load      = !r_out_valid || i_out_ready;
    assign w_wr_en     = (r_state == ST_DECIDE) && n_wr;
    assign w_div_wait  = (r_state == ST_C_WAIT) || (r_state == ST_P_WAIT);
    assign w_out_chg   = r_out_valid && r_out.parent_changed;

    // A freshly allocated entry starts from zero counts.
    always_comb begin
        w_base = r_ent;
        if (!r_s_hit) begin
            w_base = '0;
            w_base.addr = r_req.sender_addr;
        end
        w_cnt_ent = f_count(w_base, r_req.beacon_seq, r_req.now_time);
    end

    // The divider computes the sender percent first, then the parent percent.
    always_comb begin
        w_div_start = (r_state == ST_C_GO) || (r_state == ST_P_GO);
        if (r_state == ST_P_GO) begin
            w_div_dvd = DIVIDEND_W'(r_p_rec) * DIVIDEND_W'(PCT_SCALE);
            w_div_dvs = (r_p_exp == 11'd0) ? 11'd1 : r_p_exp;
        end else begin
            w_div_dvd = DIVIDEND_W'(r_ent.received) * DIVIDEND_W'(PCT_SCALE);
            w_div_dvs = (r_ent.expected == 11'd0) ? 11'd1 : r_ent.expected;
        end
    end

    // Parent selection and the result of the transaction.
    always_comb begin
        logic [DIVIDEND_W-1:0] pc;
        logic [DIVIDEND_W-1:0] pp;
        logic [10:0]           ec;
        logic [15:0]           cand;
        logic                  none;
        logic                  accept;
        logic                  cond;
        pc = r_k_ok ? r_pc : '0;
        ec = r_k_ok ? r_ent.expected : 11'd0;
        cand = r_req.beacon_metric + 16'd1;
        none = (r_parent == 16'd0);
        pp = (none || !r_p_hit) ? '0 : r_pp;
        accept = 1'b0;
        cond = 1'b0;
        n_ent = r_ent;
        n_parent = r_parent;
        n_hop = r_hop;
        n_own_seq = r_own_seq;
        n_dwell_until = r_dwell_until;
        n_heard_at = r_heard_at;
        n_wr = 1'b0;
        n_out = '0;
        case (r_req.req_type)
            REQ_BEACON: begin
                n_wr = r_k_ok;
                n_out.entry_missing = !r_k_ok;
                if (!r_sink) begin
                    if (!none && r_req.sender_addr == r_parent &&
                        r_req.beacon_metric != NO_METRIC) begin
                        n_hop = cand;
                        n_heard_at = r_req.now_time;
                    end
                    if (r_own_seq < r_req.beacon_seq) begin
                        n_own_seq = r_req.beacon_seq;
                    end
                    if (r_req.beacon_metric != NO_METRIC && r_req.sender_addr != 16'd0) begin
                        if (none) begin
                            accept = ec >= {1'b0, r_min_samples};
                        end else if (cand < n_hop) begin
                            accept = (ec >= {1'b0, r_min_samples}) &&
                                     (pc >= DIVIDEND_W'(r_better_pct));
                        end else if (cand == n_hop && !(r_req.now_time < r_dwell_until) &&
                                     r_k_ok) begin
                            cond = (ec >= {1'b0, r_min_samples}) &&
                                   ({1'b0, pc} >= ({1'b0, pp} + (DIVIDEND_W + 1)'(r_margin_pct)));
                            if (cond) begin
                                if (r_ent.streak < STREAK_MAX) begin
                                    n_ent.streak = r_ent.streak + 8'd1;
                                end
                            end else begin
                                n_ent.streak = 8'd0;
                            end
                            accept = n_ent.streak >= r_wins;
                        end
                        if (accept) begin
                            n_out.parent_changed = (r_parent != r_req.sender_addr);
                            n_parent = r_req.sender_addr;
                            n_hop = cand;
                            n_heard_at = r_req.now_time;
                            n_dwell_until = r_req.now_time + r_dwell_ticks;
                        end
                    end
                    n_out.forward_beacon = (n_hop != NO_METRIC);
                end
                n_out.link_percent = pc[6:0];
                n_out.link_samples = ec[9:0];
            end
            REQ_TIMEOUT: begin
                if (!r_sink && !none && (r_req.now_time - r_heard_at) >= r_timeout) begin
                    n_parent = 16'd0;
                    n_hop = NO_METRIC;
                end
            end
            REQ_QUERY: begin
                n_out.entry_missing = !r_k_ok;
                n_out.link_percent = pc[6:0];
                n_out.link_samples = ec[9:0];
            end
            default: begin
                n_wr = 1'b0;
            end
        endcase
        n_out.parent_addr = n_parent;
        n_out.node_metric = r_sink ? 16'd0 : n_hop;
        n_out.seq_to_forward = n_own_seq;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sink        <= 1'b0;
            r_timeout     <= 32'd5760;
            r_dwell_ticks <= 32'd5760;
            r_better_pct  <= 7'd30;
            r_margin_pct  <= 7'd10;
            r_min_samples <= 10'd3;
            r_wins        <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SINK_MODE:   r_sink        <= i_cfg_wdata[0];
                CFG_TIMEOUT:     r_timeout     <= i_cfg_wdata;
                CFG_DWELL:       r_dwell_ticks <= i_cfg_wdata;
                CFG_BETTER_PCT:  r_better_pct  <= i_cfg_wdata[6:0];
                CFG_MARGIN_PCT:  r_margin_pct  <= i_cfg_wdata[6:0];
                CFG_MIN_SAMPLES: r_min_samples <= i_cfg_wdata[9:0];
                CFG_WINS:        r_wins        <= i_cfg_wdata[7:0];
                default:         r_sink        <= r_sink;
            endcase
        end
    end

    // Sequencer, node state and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_parent      <= 16'd0;
            r_hop         <= NO_METRIC;
            r_own_seq     <= 16'd0;
            r_dwell_until <= 32'd0;
            r_heard_at    <= 32'd0;
            r_out_valid   <= 1'b0;
            r_chk_v       <= 1'b0;
            r_idx         <= '0;
        end else begin
            // The output register loads a new result or empties on acceptance.
            if (r_state == ST_OUT && w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_idx   <= '0;
                        r_chk_v <= 1'b0;
                        r_s_hit <= 1'b0;
                        r_p_hit <= 1'b0;
                        r_f_hit <= 1'b0;
                        r_k_ok  <= 1'b0;
                        if (i_in_data.req_type == REQ_BEACON ||
                            i_in_data.req_type == REQ_QUERY) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_SCAN: begin
                    // Reads run one entry ahead of the compare.
                    r_chk_v   <= r_idx < CNT_W'(TABLE_ENTRIES);
                    r_chk_idx <= r_idx[IDX_W-1:0];
                    if (r_idx < CNT_W'(TABLE_ENTRIES)) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (r_chk_v) begin
                        if (w_chk_valid && w_rd_data.addr == r_req.sender_addr && !r_s_hit) begin
                            r_s_hit <= 1'b1;
                            r_s_idx <= r_chk_idx;
                            r_ent   <= w_rd_data;
                        end
                        if (w_chk_valid && w_rd_data.addr == r_parent && !r_p_hit) begin
                            r_p_hit <= 1'b1;
                            r_p_idx <= r_chk_idx;
                            r_p_rec <= w_rd_data.received;
                            r_p_exp <= w_rd_data.expected;
                        end
                        if (!w_chk_valid && !r_f_hit) begin
                            r_f_hit <= 1'b1;
                            r_f_idx <= r_chk_idx;
                        end
                    end
                    if (w_scan_end) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (r_req.req_type == REQ_BEACON) begin
                        r_k_ok  <= r_s_hit || r_f_hit;
                        r_k_idx <= r_s_hit ? r_s_idx : r_f_idx;
                        r_ent   <= w_cnt_ent;
                        // When the sender is the parent, the parent percent
                        // sees the counts of this beacon.
                        if (r_s_hit && r_p_hit && r_p_idx == r_s_idx) begin
                            r_p_rec <= w_cnt_ent.received;
                            r_p_exp <= w_cnt_ent.expected;
                        end
                    end else begin
                        r_k_ok  <= r_s_hit;
                        r_k_idx <= r_s_idx;
                    end
                    r_state <= ST_C_GO;
                end
                ST_C_GO: begin
                    r_state <= ST_C_WAIT;
                end
                ST_C_WAIT: begin
                    if (w_div.done) begin
                        r_pc    <= w_div.quot;
                        r_state <= ST_P_GO;
                    end
                end
                ST_P_GO: begin
                    r_state <= ST_P_WAIT;
                end
                ST_P_WAIT: begin
                    if (w_div.done) begin
                        r_pp    <= w_div.quot;
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_ent         <= n_ent;
                    r_parent      <= n_parent;
                    r_hop         <= n_hop;
                    r_own_seq     <= n_own_seq;
                    r_dwell_until <= n_dwell_until;
                    r_heard_at    <= n_heard_at;
                    r_res         <= n_out;
                    r_state       <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `LQPS_ASSERT_IMPLIES(a_div_done_in_wait, i_clk, i_rst_n, w_div.done, w_div_wait)
    `LQPS_ASSERT_IMPLIES(a_scan_in_range, i_clk, i_rst_n, r_state == ST_SCAN, r_idx <= CNT_W'(TABLE_ENTRIES))
    `LQPS_ASSERT_IMPLIES(a_change_has_parent, i_clk, i_rst_n, w_out_chg, r_out.parent_addr != 16'd0)
    `LQPS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != ST_IDLE)

endmodule

FILE: test/tb_link_quality_parent_selector_top.sv
// Self-checking testbench for the link quality parent selector top level.
module tb_link_quality_parent_selector_top;
    import lqps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBR_SLOTS = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_wdata = '0;

    link_quality_parent_selector_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    // The clock toggles every half period of 4 ns.
    always #4 i_clk = ~i_clk;

    // Shadow copy of the neighbor table and the routing state, kept by the predictor.
    logic [15:0] nb_addr     [NBR_SLOTS];
    logic [15:0] nb_seq      [NBR_SLOTS];
    logic [10:0] nb_rcv      [NBR_SLOTS];
    logic [10:0] nb_exp      [NBR_SLOTS];
    logic [7:0]  nb_streak   [NBR_SLOTS];
    logic        nb_used     [NBR_SLOTS];
    logic [15:0] sh_parent;
    logic [15:0] sh_metric;
    logic [15:0] sh_seq;
    logic [31:0] sh_dwell_end;
    logic [31:0] sh_parent_seen;

    // Shadow copy of the configuration registers.
    logic        cf_sink;
    logic [31:0] cf_timeout;
    logic [31:0] cf_dwell;
    logic [6:0]  cf_better_pct;
    logic [6:0]  cf_margin_pct;
    logic [9:0]  cf_min_samples;
    logic [7:0]  cf_wins;

    t_in  pending_beacons [$];   // Transactions waiting to be driven.
    t_out expected_status [$];   // Predicted results, oldest first.

    int  error_count = 0;
    int  idle_pct = 0;           // Chance in percent that the driver holds off.
    int  stall_pct = 0;          // Chance in percent that the monitor stalls.

    // Set at the rising edge when the presented transaction was taken, so the
    // driver knows at the next falling edge that it may move on.
    logic o_in_ready_seen = 1'b0;

    function automatic int find_nbr(logic [15:0] a);
        for (int k = 0; k < NBR_SLOTS; k++)
            if (nb_used[k] && nb_addr[k] == a)
                return k;
        return -1;
    endfunction

    function automatic int pct_for(int k);
        int e;
        if (k < 0)
            return 0;
        e = (nb_exp[k] != 0) ? int'(nb_exp[k]) : 1;
        return (int'(nb_rcv[k]) * 100) / e;
    endfunction

    function automatic int samples_for(int k);
        return (k < 0) ? 0 : int'(nb_exp[k]);
    endfunction

    // Updates the reception counts of one neighbor from the sequence gap.
    function automatic void tally_beacon(int k, logic [15:0] seq);
        logic [15:0] gap;
        int e;
        int r;
        if (nb_exp[k] == 0 && nb_rcv[k] == 0) begin
            nb_seq[k] = seq;
            nb_rcv[k] = 1;
            nb_exp[k] = 1;
            return;
        end
        gap = seq - nb_seq[k];
        if (gap == 0)
            return;
        if (gap > 16'd1000) begin
            nb_seq[k] = seq;
            nb_rcv[k] = 1;
            nb_exp[k] = 1;
            return;
        end
        e = int'(nb_exp[k]) + int'(gap);
        r = int'(nb_rcv[k]) + 1;
        nb_seq[k] = seq;
        if (e > 1000 || r > 1000) begin
            e = (e + 1) >> 1;
            r = (r + 1) >> 1;
            if (e == 0)
                e = 1;
        end
        nb_exp[k] = e[10:0];
        nb_rcv[k] = r[10:0];
    endfunction

    // Predicts the result of one transaction and advances the shadow state.
    function automatic t_out predict_selection(t_in it);
        t_out o;
        int   k;
        int   pc;
        int   pp;
        int   ec;
        bit   accept;
        bit   none;
        bit   qualifies;
        logic [15:0] cand;
        o = '0;
        if (it.req_type == REQ_BEACON) begin
            k = find_nbr(it.sender_addr);
            if (k < 0) begin
                for (int j = 0; j < NBR_SLOTS; j++)
                    if (!nb_used[j]) begin
                        nb_used[j] = 1'b1;
                        nb_addr[j] = it.sender_addr;
                        nb_seq[j] = 0;
                        nb_rcv[j] = 0;
                        nb_exp[j] = 0;
                        nb_streak[j] = 0;
                        k = j;
                        break;
                    end
            end
            if (k >= 0)
                tally_beacon(k, it.beacon_seq);
            else
                o.entry_missing = 1'b1;
            if (!cf_sink) begin
                if (sh_parent != 0 && it.sender_addr == sh_parent
                        && it.beacon_metric != NO_METRIC) begin
                    sh_metric = it.beacon_metric + 16'd1;
                    sh_parent_seen = it.now_time;
                end
                if (sh_seq < it.beacon_seq)
                    sh_seq = it.beacon_seq;
                if (it.beacon_metric != NO_METRIC && it.sender_addr != 0) begin
                    cand = it.beacon_metric + 16'd1;
                    none = (sh_parent == 0);
                    pc = pct_for(k);
                    pp = none ? 0 : pct_for(find_nbr(sh_parent));
                    ec = samples_for(k);
                    accept = 1'b0;
                    if (none) begin
                        accept = ec >= int'(cf_min_samples);
                    end else if (cand < sh_metric) begin
                        accept = ec >= int'(cf_min_samples) && pc >= int'(cf_better_pct);
                    end else if (cand == sh_metric && !(it.now_time < sh_dwell_end)
                            && k >= 0) begin
                        qualifies = ec >= int'(cf_min_samples)
                                    && pc >= pp + int'(cf_margin_pct);
                        if (qualifies) begin
                            if (nb_streak[k] < STREAK_MAX)
                                nb_streak[k]++;
                        end else begin
                            nb_streak[k] = 0;
                        end
                        accept = nb_streak[k] >= cf_wins;
                    end
                    if (accept) begin
                        o.parent_changed = (sh_parent != it.sender_addr);
                        sh_parent = it.sender_addr;
                        sh_metric = cand;
                        sh_parent_seen = it.now_time;
                        sh_dwell_end = it.now_time + cf_dwell;
                    end
                end
                o.forward_beacon = (sh_metric != NO_METRIC);
            end
            o.link_percent = 7'(pct_for(k));
            o.link_samples = 10'(samples_for(k));
        end else if (it.req_type == REQ_TIMEOUT) begin
            if (!cf_sink && sh_parent != 0
                    && (it.now_time - sh_parent_seen) >= cf_timeout) begin
                sh_parent = 0;
                sh_metric = NO_METRIC;
            end
        end else if (it.req_type == REQ_QUERY) begin
            k = find_nbr(it.sender_addr);
            o.entry_missing = (k < 0);
            o.link_percent = 7'(pct_for(k));
            o.link_samples = 10'(samples_for(k));
        end
        o.parent_addr = sh_parent;
        o.node_metric = cf_sink ? 16'd0 : sh_metric;
        o.seq_to_forward = sh_seq;
        return o;
    endfunction

    // Driver: presents queued transactions at the falling edge and keeps valid
    // and the payload steady until the block takes them.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready_seen) begin
                if (pending_beacons.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_data <= pending_beacons.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: predicts on every accepted input and checks every accepted result.
    always @(posedge i_clk) begin
        t_out got;
        t_out exp_o;
        o_in_ready_seen <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_status.push_back(predict_selection(i_in_data));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_data;
            if (expected_status.size() == 0) begin
                $error("result without a pending transaction: %p", got);
                error_count++;
            end else begin
                exp_o = expected_status.pop_front();
                if (got.parent_addr !== exp_o.parent_addr) begin
                    $error("parent_addr expected %0d got %0d", exp_o.parent_addr,
                           got.parent_addr);
                    error_count++;
                end
                if (got.node_metric !== exp_o.node_metric) begin
                    $error("node_metric expected %0d got %0d", exp_o.node_metric,
                           got.node_metric);
                    error_count++;
                end
                if (got.seq_to_forward !== exp_o.seq_to_forward) begin
                    $error("seq_to_forward expected %0d got %0d", exp_o.seq_to_forward,
                           got.seq_to_forward);
                    error_count++;
                end
                if (got.link_percent !== exp_o.link_percent) begin
                    $error("link_percent expected %0d got %0d", exp_o.link_percent,
                           got.link_percent);
                    error_count++;
                end
                if (got.link_samples !== exp_o.link_samples) begin
                    $error("link_samples expected %0d got %0d", exp_o.link_samples,
                           got.link_samples);
                    error_count++;
                end
                if (got.parent_changed !== exp_o.parent_changed) begin
                    $error("parent_changed expected %0d got %0d", exp_o.parent_changed,
                           got.parent_changed);
                    error_count++;
                end
                if (got.forward_beacon !== exp_o.forward_beacon) begin
                    $error("forward_beacon expected %0d got %0d", exp_o.forward_beacon,
                           got.forward_beacon);
                    error_count++;
                end
                if (got.entry_missing !== exp_o.entry_missing) begin
                    $error("entry_missing expected %0d got %0d", exp_o.entry_missing,
                           got.entry_missing);
                    error_count++;
                end
            end
        end
    end

    // Writes one register at a falling edge; the block takes it at the next
    // rising edge, and the shadow copy follows at once since the block is idle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SINK_MODE:   cf_sink = val[0];
            CFG_TIMEOUT:     cf_timeout = val;
            CFG_DWELL:       cf_dwell = val;
            CFG_BETTER_PCT:  cf_better_pct = val[6:0];
            CFG_MARGIN_PCT:  cf_margin_pct = val[6:0];
            CFG_MIN_SAMPLES: cf_min_samples = val[9:0];
            CFG_WINS:        cf_wins = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(bit sink, logic [31:0] tmo, logic [31:0] dw, int bp,
                             int mp, int ms, int wn);
        write_reg(CFG_SINK_MODE, 32'(sink));
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_DWELL, dw);
        write_reg(CFG_BETTER_PCT, 32'(bp));
        write_reg(CFG_MARGIN_PCT, 32'(mp));
        write_reg(CFG_MIN_SAMPLES, 32'(ms));
        write_reg(CFG_WINS, 32'(wn));
    endtask

    // Waits until every queued transaction has gone in and every result has come
    // back, then lets the block settle before the next register write.
    task automatic drain_phase();
        while (pending_beacons.size() > 0 || i_in_valid || expected_status.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_in make_item(logic [1:0] rt, logic [15:0] a, logic [15:0] s,
                                      logic [15:0] m, logic [31:0] t);
        t_in it;
        it.req_type = rt;
        it.sender_addr = a;
        it.beacon_seq = s;
        it.beacon_metric = m;
        it.now_time = t;
        return it;
    endfunction

    // A random item: mostly beacons from a small neighborhood with short
    // sequence gaps and a slowly moving clock, plus wide noise now and then.
    logic [31:0] sim_now = 0;
    logic [15:0] nbr_seqs [8];

    function automatic t_in random_item(int pool);
        int sel;
        int who;
        logic [15:0] a;
        sel = $urandom_range(99);
        sim_now += $urandom_range(400);
        who = $urandom_range(pool - 1);
        a = 16'(who + 1);
        if (sel < 70) begin
            nbr_seqs[who] += 16'($urandom_range(3));
            if ($urandom_range(19) == 0)
                nbr_seqs[who] += 16'($urandom_range(65535));
            return make_item(REQ_BEACON, a, nbr_seqs[who], 16'($urandom_range(4)),
                             sim_now);
        end else if (sel < 80) begin
            return make_item(REQ_TIMEOUT, a, 16'($urandom), 16'($urandom), sim_now);
        end else if (sel < 88) begin
            return make_item(REQ_QUERY, a, 16'($urandom), 16'($urandom), sim_now);
        end else begin
            return make_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                             16'($urandom), $urandom);
        end
    endfunction

    task automatic run_random(int count, int pool, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
            pending_beacons.push_back(random_item(pool));
        drain_phase();
    endtask

    initial begin
        for (int k = 0; k < NBR_SLOTS; k++)
            nb_used[k] = 1'b0;
        sh_parent = 0;
        sh_metric = NO_METRIC;
        sh_seq = 0;
        sh_dwell_end = 0;
        sh_parent_seen = 0;
        cf_sink = 1'b0;
        cf_timeout = 5760;
        cf_dwell = 5760;
        cf_better_pct = 30;
        cf_margin_pct = 10;
        cf_min_samples = 3;
        cf_wins = 2;
        for (int k = 0; k < 8; k++)
            nbr_seqs[k] = 16'($urandom);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a join, a sequence reset, a zero address, extreme
        // fields, a query of an absent neighbor, an unused request and a timeout.
        write_all(1'b0, 32'd100, 32'd0, 0, 0, 1, 1);
        pending_beacons.push_back(make_item(REQ_QUERY, 16'hFFFF, 0, 0, 0));
        pending_beacons.push_back(make_item(REQ_BEACON, 16'd5, 16'd10, 16'd2, 32'd10));
        pending_beacons.push_back(make_item(REQ_BEACON, 16'd5, 16'd10, 16'd2, 32'd11));
        pending_beacons.push_back(make_item(REQ_BEACON, 16'd5, 16'd12, 16'd2, 32'd12));
        pending_beacons.push_back(make_item(REQ_BEACON, 16'd5, 16'd3000, 16'd2, 32'd13));
        pending_beacons.push_back(make_item(REQ_BEACON, 16'd0, 16'hFFFF, 16'd0, 32'd14));
        pending_beacons.push_back(make_item(REQ_BEACON, 16'd7, 16'd1, 16'd0, 32'd15));
        pending_beacons.push_back(make_item(REQ_BEACON, 16'd9, 16'd1, 16'd1, 32'd16));
        pending_beacons.push_back(make_item(REQ_BEACON, 16'd9, 16'd2, 16'd1, 32'd17));
        pending_beacons.push_back(make_item(REQ_BEACON, 16'hFFFF, 16'd4, NO_METRIC,
                                            32'hFFFF_FFFF));
        pending_beacons.push_back(make_item(REQ_QUERY, 16'd5, 0, 0, 0));
        pending_beacons.push_back(make_item(REQ_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                            32'hFFFF_FFFF));
        pending_beacons.push_back(make_item(REQ_TIMEOUT, 0, 0, 0, 32'd50));
        pending_beacons.push_back(make_item(REQ_TIMEOUT, 0, 0, 0, 32'd5000));
        drain_phase();

        // Random phases: different idling mixes and register settings,
        // with a sink phase and the register extremes among them.
        write_all(1'b0, 32'd1500, 32'd800, 30, 10, 3, 2);
        run_random(150, 6, 0, 0);
        write_all(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 100, 1000, 255);
        run_random(120, 8, 84, 0);
        write_all(1'b1, 32'd0, 32'd0, 0, 0, 1, 1);
        run_random(100, 8, 0, 84);
        write_all(1'b0, 32'd0, 32'd0, 0, 0, 1, 1);
        run_random(130, 5, 33, 33);
        write_all(1'b0, 32'd2000, 32'd300, 50, 5, 2, 3);
        run_random(150, 4, 0, 0);
        write_all(1'b0, 32'd5760, 32'd5760, 30, 10, 3, 2);
        run_random(100, 8, 33, 33);

        // Overflow the table: one more sender than there are entries.
        for (int k = 0; k < NBR_SLOTS + 1; k++)
            pending_beacons.push_back(make_item(REQ_BEACON, 16'(16'h100 + k), 16'd1,
                                                16'd3, 32'd6000));
        drain_phase();

        if (error_count == 0) begin
            $display("PASS link_quality_parent_selector_top");
        end else begin
            $display("FAIL link_quality_parent_selector_top");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #40ms;
        $display("FAIL link_quality_parent_selector_top");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/lqps_pkg.sv
hdl/lqps_table.sv
hdl/lqps_div.sv
hdl/link_quality_parent_selector_top.sv
test/tb_link_quality_parent_selector_top.sv
